### rtl/rzvd_pkg.sv
// rzvd_pkg: shared types and constants of the remap zigzag varint delta encoder
// used by the interfaces, the divider and the top level; depends on nothing
`timescale 1ns / 1ps

package rzvd_pkg;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_ENCODE = 2'd1,
        OP_END    = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_EMIT   = 4'b0100,
        S_SINGLE = 4'b1000
    } t_state;

    // register indexes on the config port
    localparam logic REG_PC_QUANTUM = 1'b0;
    localparam logic REG_MAP_COUNT  = 1'b1;

    localparam int  GROUP_BITS   = 7;
    localparam logic [31:0] PREV_RESET = 32'hFFFF_FFFF;
    localparam logic [8:0]  IDX_NONE   = 9'h1FF;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [2:0]  divisor;
    } t_div_req;

endpackage

### rtl/rzvd_in_if.sv
// rzvd_in_if: input channel of the encoder, valid/ready plus item payload
// depends on rzvd_pkg
`timescale 1ns / 1ps

interface rzvd_in_if
    import rzvd_pkg::*;
;
    logic              valid;
    logic              ready;
    t_opcode           opcode;
    logic signed [8:0] file_index;
    logic [30:0]       map_value;
    logic [31:0]       pc_span;

    modport source (output valid, opcode, file_index, map_value, pc_span, input ready);
    modport sink   (input valid, opcode, file_index, map_value, pc_span, output ready);
endinterface

### rtl/rzvd_out_if.sv
// rzvd_out_if: result channel of the encoder, one varint byte per beat
// depends on rzvd_pkg
`timescale 1ns / 1ps

interface rzvd_out_if
    import rzvd_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       bad_index;

    modport source (output valid, out_byte, last, bad_index, input ready);
    modport sink   (input valid, out_byte, last, bad_index, output ready);
endinterface

### rtl/rzvd_ram.sv
// rzvd_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rzvd_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rzvd_div.sv
// rzvd_div: iterative restoring divider, 32-bit dividend by 3-bit divisor
// four quotient bits per cycle; depends on rzvd_pkg
`timescale 1ns / 1ps

module rzvd_div
    import rzvd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy, n_busy;
    logic [2:0]  r_cnt, n_cnt;
    logic [31:0] r_num, n_num;
    logic [2:0]  r_rem, n_rem;
    logic [2:0]  r_dvs, n_dvs;

    always_comb begin
        logic [3:0]  t;
        logic [31:0] num;
        logic [2:0]  rem;
        logic        ge;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        num    = r_num;
        rem    = r_rem;
        for (int j = 0; j < 4; j++) begin
            t   = {rem, num[31]};
            ge  = (t >= {1'b0, r_dvs});
            num = {num[30:0], ge};
            rem = ge ? 3'(t - {1'b0, r_dvs}) : t[2:0];
        end
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_req.dividend;
            n_rem  = '0;
            // zero quantum acts as one
            n_dvs  = (i_req.divisor == 3'd0) ? 3'd1 : i_req.divisor;
        end else if (r_busy) begin
            n_num = num;
            n_rem = rem;
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = !r_busy;
    assign o_quotient = r_num;

endmodule

### rtl/remap_zigzag_varint_delta_encoder.sv
// remap_zigzag_varint_delta_encoder: top level, fsm, remap ram, apb registers
// depends on rzvd_pkg, rzvd_in_if, rzvd_out_if, rzvd_ram, rzvd_div
`timescale 1ns / 1ps
//
// usage
//   i_in carries one item per beat: a remap write, an encode run or an end mark.
//   o_out carries one varint byte per beat; last marks the final byte of an item,
//   bad_index flags the single error beat of an encode with an out-of-range index.
//   apb port: pc_quantum at 0x0, map_count at 0x4, pready always high.
// timing
//   a remap write gives no beat; the ram port is written at the accept edge.
//   an end or a bad encode passes through S_SINGLE and gives one beat.
//   a good encode reads the remap ram (an index of none gives -1) in S_READ,
//   then sends the delta bytes one per cycle while the receiver is ready, with
//   the 4-bit-per-cycle span divider running alongside; the last delta byte
//   waits until the divider is done, then the span bytes follow. one item at a time.
// reset
//   synchronous, active low: pc_quantum 1, map_count 0, previous value -1,
//   output empty. the remap ram is not cleared; read only written slots.
// stall
//   the output register holds its beat while o_out.ready is low and the byte
//   sequencer waits; a new item is taken as soon as the sequencer is idle, even
//   with the last beat still waiting in the output register.

module remap_zigzag_varint_delta_encoder
    import rzvd_pkg::*;
#(
    parameter int MAP_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rzvd_in_if.sink     i_in,
    rzvd_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    // config registers
    logic [2:0] r_pc_quantum;
    logic [8:0] r_map_count;
    logic       w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_MAP_COUNT) ? {23'd0, r_map_count}
                                                  : {29'd0, r_pc_quantum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc_quantum <= 3'd1;
            r_map_count  <= 9'd0;
        end else if (w_cfg_we) begin
            unique case (paddr[2])
                REG_PC_QUANTUM: r_pc_quantum <= pwdata[2:0];
                REG_MAP_COUNT:  r_map_count  <= pwdata[8:0];
            endcase
        end
    end

    // sequencer state
    t_state      r_state, n_state;
    logic [31:0] r_prev, n_prev;
    logic [31:0] r_word, n_word;
    logic        r_phase, n_phase;
    logic        r_none, n_none;
    logic        r_bad, n_bad;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;
    logic        r_out_bad, n_out_bad;
    logic        w_out_free;

    // input decode
    logic        w_accept;
    logic [8:0]  w_raw;
    logic [16:0] w_idx_ext;
    logic        w_in_depth;
    logic        w_is_none;
    logic        w_idx_bad;

    // ram and divider
    logic          w_ram_we;
    logic          w_ram_re;
    logic [AW-1:0] w_addr;
    logic [30:0]   w_rdata;
    t_div_req      w_div_req;
    logic          w_div_done;
    logic [31:0]   w_quot;

    // value delta path
    logic [31:0] w_val;
    logic [31:0] w_dv;
    logic [31:0] w_zz;
    logic        w_more;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_raw      = i_in.file_index;
    assign w_idx_ext  = {9'd0, w_raw[7:0]};
    assign w_in_depth = !w_raw[8] && (w_idx_ext < 17'(MAP_DEPTH));
    assign w_is_none  = (w_raw == IDX_NONE);
    // negative other than none, or not below map_count or the table depth
    assign w_idx_bad  = !w_is_none &&
                        (w_raw[8] || ({1'b0, w_raw[7:0]} >= r_map_count) || !w_in_depth);
    assign w_addr     = w_idx_ext[AW-1:0];

    assign w_ram_we = w_accept && (i_in.opcode == OP_WRITE) && w_in_depth;
    assign w_ram_re = w_accept && (i_in.opcode == OP_ENCODE) && !w_idx_bad && !w_is_none;

    assign w_div_req.start    = w_accept && (i_in.opcode == OP_ENCODE) && !w_idx_bad;
    assign w_div_req.dividend = i_in.pc_span;
    assign w_div_req.divisor  = r_pc_quantum;

    rzvd_ram #(
        .WIDTH (31),
        .DEPTH (MAP_DEPTH)
    ) u_remap_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_addr),
        .i_wdata (i_in.map_value),
        .i_re    (w_ram_re),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    rzvd_div u_span_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // remapped value, delta from the previous one, zigzag fold
    assign w_val  = r_none ? PREV_RESET : {1'b0, w_rdata};
    assign w_dv   = w_val - r_prev;
    assign w_zz   = {w_dv[30:0], 1'b0} ^ {32{w_dv[31]}};
    assign w_more = |r_word[31:GROUP_BITS];

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_word      = r_word;
        n_phase     = r_phase;
        n_none      = r_none;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.opcode)
                        OP_WRITE: begin
                        end
                        OP_ENCODE: begin
                            if (w_idx_bad) begin
                                n_bad   = 1'b1;
                                n_state = S_SINGLE;
                            end else begin
                                n_none  = w_is_none;
                                n_state = S_READ;
                            end
                        end
                        OP_END: begin
                            n_bad   = 1'b0;
                            n_prev  = PREV_RESET;
                            n_state = S_SINGLE;
                        end
                        OP_RSVD: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_prev  = w_val;
                n_word  = w_zz;
                n_phase = 1'b0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    if (w_more) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = {1'b1, r_word[6:0]};
                        n_out_last  = 1'b0;
                        n_out_bad   = 1'b0;
                        n_word      = r_word >> GROUP_BITS;
                    end else if (!r_phase) begin
                        // last delta byte goes out once the span quotient is ready
                        if (w_div_done) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = {1'b0, r_word[6:0]};
                            n_out_last  = 1'b0;
                            n_out_bad   = 1'b0;
                            n_word      = w_quot;
                            n_phase     = 1'b1;
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_byte  = {1'b0, r_word[6:0]};
                        n_out_last  = 1'b1;
                        n_out_bad   = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_SINGLE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = 8'd0;
                    n_out_last  = 1'b1;
                    n_out_bad   = r_bad;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= PREV_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
        r_word     <= n_word;
        r_phase    <= n_phase;
        r_none     <= n_none;
        r_bad      <= n_bad;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.last      = r_out_last;
    assign o_out.bad_index = r_out_bad;

`ifndef ASSERT_OFF
    // a good encode always goes through the ram read cycle
    a_encode_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.opcode == OP_ENCODE) && !w_idx_bad) |=> (r_state == S_READ))
        else $error("encode did not enter ram read");

    // span bytes are only sent after the divider has finished
    a_span_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && r_phase) |-> w_div_done)
        else $error("span phase with divider busy");

    // an error beat is a lone zero byte
    a_bad_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.bad_index) |-> (o_out.last && (o_out.out_byte == 8'd0)))
        else $error("malformed error beat");

    // previous value moves only after a ram read or an end item
    a_prev_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_prev)) |->
        ($past(r_state == S_READ) || $past(w_accept && (i_in.opcode == OP_END))))
        else $error("unexpected previous value update");
`endif

endmodule
